@@ sv/hte_pkg.sv @@
// Shared types and sizes for the chained hash table engine.
// No dependencies; imported by every module of the block.
package hte_pkg;

    localparam int BUCKETS = 256;
    localparam int NODES   = 256;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int NODE_W  = $clog2(NODES);
    localparam int CNT_W   = $clog2(NODES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    typedef enum logic [1:0] {
        ACT_PUT = 2'd0,
        ACT_GET = 2'd1,
        ACT_DEL = 2'd2,
        ACT_CLR = 2'd3
    } action_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic head_step;
        logic link_step;
        logic set_found;
        logic commit;
        logic res_load;
    } hte_cmd_t;

    // datapath -> controller
    typedef struct packed {
        action_t action;
        logic    head_ok;
        logic    hit;
        logic    link_ok;
        logic    walk_end;
        logic    out_free;
    } hte_stat_t;

endpackage

@@ sv/hte_ctrl.sv @@
// Operation sequencer: head read, chain walk, commit, result hand-off.
// Depends on hte_pkg.
module hte_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hte_pkg::hte_stat_t stat,
    output hte_pkg::hte_cmd_t  cmd
);
    import hte_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_NODE,
        ST_COMMIT,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                if (stat.action == ACT_CLR)
                    state_next = ST_COMMIT;
                else if (stat.head_ok)
                begin
                    cmd.head_step = 1'b1;
                    state_next    = ST_NODE;
                end
                else
                    state_next = ST_COMMIT;
            end
            ST_NODE:
            begin
                priority if (stat.hit)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = ST_COMMIT;
                end
                else if (stat.link_ok && !stat.walk_end)
                    cmd.link_step = 1'b1;
                else
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // a hit can only be taken while walking a chain
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_found |-> state_reg == ST_NODE)
        else $error("hit outside chain walk");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == ST_RESULT)
        else $error("commit not followed by result");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !in_ready)
        else $error("second word taken during operation");

endmodule

@@ sv/hte_datapath.sv @@
// Table storage (bucket heads, node pool, recycle stack), walk registers
// and the result register. Depends on hte_pkg.
module hte_datapath
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  hte_pkg::action_t         in_action,
    input  logic [hte_pkg::KEY_W-1:0] in_key,
    input  logic [hte_pkg::VAL_W-1:0] in_value,
    input  logic                     in_preserve,
    input  hte_pkg::hte_cmd_t        cmd,
    output hte_pkg::hte_stat_t       stat,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic                     out_ok,
    output logic                     out_found,
    output logic [hte_pkg::VAL_W-1:0] out_value,
    output logic [hte_pkg::CNT_W-1:0] out_count,
    output logic                     out_status
);
    import hte_pkg::*;

    // item registers
    action_t           act_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              pres_reg;
    logic [BKT_W-1:0]  bucket;

    // memories
    logic [NODE_W-1:0] head_mem  [BUCKETS];
    logic [KEY_W-1:0]  key_mem   [NODES];
    logic [VAL_W-1:0]  value_mem [NODES];
    logic [NODE_W:0]   link_mem  [NODES];   // {valid, index}
    logic [NODE_W-1:0] stack_mem [NODES];
    logic [BUCKETS-1:0] hvalid_reg;

    logic [NODE_W-1:0] head_q;
    logic [KEY_W-1:0]  key_q;
    logic [VAL_W-1:0]  value_q;
    logic [NODE_W:0]   link_q;
    logic [NODE_W-1:0] stack_q;

    // walk and bookkeeping
    logic [NODE_W-1:0] cur_reg, pred_reg, steps_reg;
    logic              pred_ok_reg, found_reg;
    logic [CNT_W-1:0]  used_reg, fresh_reg, sp_reg;

    logic              res_ok_reg, res_found_reg, res_status_reg;
    logic [VAL_W-1:0]  res_val_reg;
    logic              out_valid_reg;

    logic [BKT_W-1:0]  head_addr;
    logic [NODE_W-1:0] node_addr, alloc_idx;
    logic              node_rd, full, put_new, put_upd, del_hit;

    assign bucket    = key_reg[BKT_W-1:0];
    assign head_addr = cmd.accept ? in_key[BKT_W-1:0] : bucket;
    assign node_rd   = cmd.head_step | cmd.link_step;
    assign node_addr = cmd.head_step ? head_q : link_q[NODE_W-1:0];
    assign full      = (used_reg == CNT_W'(NODES));
    assign alloc_idx = (sp_reg != '0) ? stack_q : fresh_reg[NODE_W-1:0];
    assign put_new   = cmd.commit && act_reg == ACT_PUT && !found_reg && !full;
    assign put_upd   = cmd.commit && act_reg == ACT_PUT && found_reg && !pres_reg;
    assign del_hit   = cmd.commit && act_reg == ACT_DEL && found_reg;

    assign stat.action   = act_reg;
    assign stat.head_ok  = hvalid_reg[bucket];
    assign stat.hit      = (key_q == key_reg);
    assign stat.link_ok  = link_q[NODE_W];
    assign stat.walk_end = (steps_reg == NODE_W'(NODES - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg  <= in_action;
            key_reg  <= in_key;
            val_reg  <= in_value;
            pres_reg <= in_preserve;
        end
    end

    // bucket heads
    always_ff @(posedge clk)
    begin
        if (put_new)
            head_mem[bucket] <= alloc_idx;
        else if (del_hit && !pred_ok_reg)
            head_mem[bucket] <= link_q[NODE_W-1:0];
        head_q <= head_mem[head_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hvalid_reg <= '0;
        else if (cmd.commit && act_reg == ACT_CLR)
            hvalid_reg <= '0;
        else if (put_new)
            hvalid_reg[bucket] <= 1'b1;
        else if (del_hit && !pred_ok_reg)
            hvalid_reg[bucket] <= link_q[NODE_W];
    end

    // node pool
    always_ff @(posedge clk)
    begin
        if (put_new)
            key_mem[alloc_idx] <= key_reg;
        if (node_rd)
            key_q <= key_mem[node_addr];
    end

    always_ff @(posedge clk)
    begin
        if (put_new)
            value_mem[alloc_idx] <= val_reg;
        else if (put_upd)
            value_mem[cur_reg] <= val_reg;
        if (node_rd)
            value_q <= value_mem[node_addr];
    end

    always_ff @(posedge clk)
    begin
        if (put_new)
            link_mem[alloc_idx] <= {hvalid_reg[bucket], head_q};
        else if (del_hit && pred_ok_reg)
            link_mem[pred_reg] <= link_q;
        if (node_rd)
            link_q <= link_mem[node_addr];
    end

    // recycle stack; top word is read continuously
    always_ff @(posedge clk)
    begin
        if (del_hit)
            stack_mem[sp_reg[NODE_W-1:0]] <= cur_reg;
        stack_q <= stack_mem[NODE_W'(sp_reg - 1'b1)];
    end

    // chain walk
    always_ff @(posedge clk)
    begin
        if (cmd.head_step)
        begin
            cur_reg   <= head_q;
            steps_reg <= '0;
        end
        else if (cmd.link_step)
        begin
            cur_reg   <= link_q[NODE_W-1:0];
            pred_reg  <= cur_reg;
            steps_reg <= steps_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_ok_reg <= 1'b0;
            found_reg   <= 1'b0;
            used_reg    <= '0;
            fresh_reg   <= '0;
            sp_reg      <= '0;
        end
        else
        begin
            if (cmd.accept)
                found_reg <= 1'b0;
            else if (cmd.set_found)
                found_reg <= 1'b1;
            if (cmd.head_step)
                pred_ok_reg <= 1'b0;
            else if (cmd.link_step)
                pred_ok_reg <= 1'b1;
            if (cmd.commit && act_reg == ACT_CLR)
            begin
                used_reg  <= '0;
                fresh_reg <= '0;
                sp_reg    <= '0;
            end
            else if (put_new)
            begin
                used_reg <= used_reg + 1'b1;
                if (sp_reg != '0)
                    sp_reg <= sp_reg - 1'b1;
                else
                    fresh_reg <= fresh_reg + 1'b1;
            end
            else if (del_hit)
            begin
                used_reg <= used_reg - 1'b1;
                sp_reg   <= sp_reg + 1'b1;
            end
        end
    end

    // result staging
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_found_reg  <= found_reg;
            res_status_reg <= 1'b0;
            res_val_reg    <= '0;
            unique case (act_reg)
                ACT_PUT:
                begin
                    if (found_reg)
                    begin
                        res_ok_reg  <= !pres_reg;
                        res_val_reg <= value_q;
                    end
                    else
                    begin
                        res_ok_reg     <= !full;
                        res_status_reg <= full;
                    end
                end
                ACT_GET:
                begin
                    res_ok_reg <= found_reg;
                    if (found_reg)
                        res_val_reg <= value_q;
                end
                ACT_DEL:
                    res_ok_reg <= found_reg;
                ACT_CLR:
                begin
                    res_ok_reg    <= 1'b1;
                    res_found_reg <= 1'b0;
                end
                default: res_ok_reg <= 1'b0;
            endcase
        end
        if (cmd.res_load)
        begin
            out_ok     <= res_ok_reg;
            out_found  <= res_found_reg;
            out_value  <= res_val_reg;
            out_count  <= used_reg;
            out_status <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg == CNT_W'(fresh_reg - sp_reg))
        else $error("entry count out of step with pool");
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(NODES))
        else $error("entry count above pool size");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status |-> !out_ok)
        else $error("refused insert reported ok");

endmodule

@@ sv/chained_hash_table_engine.sv @@
// Top level of the chained hash table engine: stream ports and word packing.
// Depends on hte_pkg, hte_ctrl, hte_datapath.
//
// Channel   Dir  Word
// s_*       in   one operation (action, key, value, preserve flag)
// m_*       out  one result per operation
//
// An operation runs from accept through the head read, one pool read per visited chain node,
// commit and the result hand-off before the next accept is taken.
// Clear and an empty bucket skip the chain walk; no sweep after reset, the table is empty at once.
// The result register frees the input side while a result waits on m_tready; the next
// operation then holds in its hand-off cycle until the waiting word is taken.
module chained_hash_table_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // lookup_key[31:0], data_value[63:32]
    input  logic [2:0]  s_tuser,    // action[1:0], preserve_existing[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // ok[0], key_found[1], out_value[33:2],
                                    // entry_count[42:34], zero[47:43]
    output logic        m_tuser     // status[0]
);
    import hte_pkg::*;

    hte_cmd_t          cmd;
    hte_stat_t         stat;
    logic              ok, found, status;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  count;

    hte_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hte_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_action   (action_t'(s_tuser[1:0])),
        .in_key      (s_tdata[31:0]),
        .in_value    (s_tdata[63:32]),
        .in_preserve (s_tuser[2]),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_ok      (ok),
        .out_found   (found),
        .out_value   (value),
        .out_count   (count),
        .out_status  (status)
    );

    assign m_tdata = {5'd0, count, value, found, ok};
    assign m_tuser = status;

endmodule
